FILE: rtl/fdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser controller package
// Shared types, event and phase codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Default width of money values (prices, cash)
    localparam int MONEY_BITS_DEF = 16;

    // Fixed field widths
    localparam int REQ_W    = 4;
    localparam int CASH_W   = 16;
    localparam int PRICE_W  = 16;
    localparam int GAL_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int CHANGE_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PRICE_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS   = REQ_W + CASH_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam logic [GAL_W-1:0]   GAL_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REG_REGULAR = 1'b0,
        CFG_REG_SUPER   = 1'b1
    } cfg_idx_t;

    // Event codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ACTIVATE  = 4'd0,
        REQ_START     = 4'd1,
        REQ_CREDIT    = 4'd2,
        REQ_REJECT    = 4'd3,
        REQ_APPROVED  = 4'd4,
        REQ_CANCEL    = 4'd5,
        REQ_CASH      = 4'd6,
        REQ_REGULAR   = 4'd7,
        REQ_SUPER     = 4'd8,
        REQ_STARTPUMP = 4'd9,
        REQ_GALLON    = 4'd10,
        REQ_STOP      = 4'd11,
        REQ_NORECEIPT = 4'd12,
        REQ_RECEIPT   = 4'd13,
        REQ_OFF       = 4'd14
    } req_t;

    // Controller phases
    typedef enum logic [3:0] {
        PH_UNACT    = 4'd0,
        PH_IDLE     = 4'd1,
        PH_WELCOME  = 4'd2,
        PH_CHECK    = 4'd3,
        PH_SELECT   = 4'd4,
        PH_SELECTED = 4'd5,
        PH_PUMP     = 4'd6,
        PH_RECEIPT  = 4'd7,
        PH_OFF      = 4'd8
    } phase_t;

    // Result beat, last field (accepted) in the lowest bits
    typedef struct packed {
        logic                funds_exhausted;
        logic [CHANGE_W-1:0] change_returned;
        logic [TOTAL_W-1:0]  total_charge;
        logic [GAL_W-1:0]    gallons_pumped;
        phase_t              phase;
        logic                accepted;
    } result_t;

    localparam int OUT_BITS   = $bits(result_t);
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/fdc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser price registers
// Holds the regular and super prices written over the configuration port.
// ----------------------------------------------------------------------------
module fdc_cfg_regs #(
    parameter int MONEY_BITS = fdc_pkg::MONEY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [MONEY_BITS-1:0]           regular_price,
    output logic [MONEY_BITS-1:0]           super_price
);
    import fdc_pkg::*;

    logic [MONEY_BITS-1:0] regular_reg;
    logic [MONEY_BITS-1:0] super_reg;
    logic [MONEY_BITS-1:0] wdata_masked;

    // Prices are kept at money width
    assign wdata_masked = MONEY_BITS'(cfg_wdata);

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regular_reg <= '0;
            super_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REG_REGULAR: regular_reg <= wdata_masked;
                CFG_REG_SUPER:   super_reg   <= wdata_masked;
                default:         regular_reg <= regular_reg;
            endcase
        end
    end

    assign regular_price = regular_reg;
    assign super_price   = super_reg;

endmodule

FILE: rtl/fdc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser event core
// Sale state registers and the combinational event update; produces the
// result of the event presented on its inputs and commits it on fire.
// ----------------------------------------------------------------------------
module fdc_core #(
    parameter int MONEY_BITS = fdc_pkg::MONEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [fdc_pkg::REQ_W-1:0]   req_type,
    input  logic [fdc_pkg::CASH_W-1:0]  cash_amount,
    input  logic [MONEY_BITS-1:0]       regular_price,
    input  logic [MONEY_BITS-1:0]       super_price,
    output fdc_pkg::result_t            result
);
    import fdc_pkg::*;

    localparam int SUM_W = TOTAL_W + 1;

    // Sale state
    phase_t                phase_reg,  phase_next;
    logic                  card_reg,   card_next;
    logic [MONEY_BITS-1:0] price_reg,  price_next;
    logic [GAL_W-1:0]      gal_reg,    gal_next;
    logic [TOTAL_W-1:0]    total_reg,  total_next;
    logic [MONEY_BITS-1:0] cash_reg,   cash_next;
    logic [MONEY_BITS-1:0] reg_latch_reg, reg_latch_next;
    logic [MONEY_BITS-1:0] sup_latch_reg, sup_latch_next;

    logic [MONEY_BITS-1:0] amt;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      cash_ext;
    logic [SUM_W-1:0]      total_ext;
    logic [SUM_W-1:0]      diff;
    logic [CHANGE_W-1:0]   change_due;
    logic                  gallon_fits;
    logic                  ok;
    logic [CHANGE_W-1:0]   change;
    logic                  exhausted;

    assign amt       = MONEY_BITS'(cash_amount);
    assign total_ext = SUM_W'(total_reg);
    assign cash_ext  = SUM_W'(cash_reg);

    // Running total plus one more gallon, checked against cash held
    assign sum         = total_ext + SUM_W'(price_reg);
    assign gallon_fits = card_reg || (sum <= cash_ext);

    // Change owed when a cash sale stops
    assign diff       = cash_ext - total_ext;
    assign change_due = (!card_reg && (total_ext < cash_ext)) ? CHANGE_W'(diff) : '0;

    // Event decode and next state
    always_comb
    begin
        phase_next     = phase_reg;
        card_next      = card_reg;
        price_next     = price_reg;
        gal_next       = gal_reg;
        total_next     = total_reg;
        cash_next      = cash_reg;
        reg_latch_next = reg_latch_reg;
        sup_latch_next = sup_latch_reg;
        ok             = 1'b0;
        change         = '0;
        exhausted      = 1'b0;

        unique case (req_type)
            REQ_ACTIVATE:
            begin
                if (phase_reg == PH_UNACT && regular_price != '0 && super_price != '0)
                begin
                    reg_latch_next = regular_price;
                    sup_latch_next = super_price;
                    phase_next     = PH_IDLE;
                    ok             = 1'b1;
                end
            end
            REQ_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_WELCOME;
                    ok         = 1'b1;
                end
            end
            REQ_CREDIT:
            begin
                if (phase_reg == PH_WELCOME)
                begin
                    phase_next = PH_CHECK;
                    ok         = 1'b1;
                end
            end
            REQ_REJECT:
            begin
                if (phase_reg == PH_CHECK)
                begin
                    phase_next = PH_IDLE;
                    ok         = 1'b1;
                end
            end
            REQ_APPROVED:
            begin
                if (phase_reg == PH_CHECK)
                begin
                    phase_next = PH_SELECT;
                    card_next  = 1'b1;
                    ok         = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                if (phase_reg == PH_SELECT)
                begin
                    phase_next = PH_IDLE;
                    if (!card_reg)
                    begin
                        change = CHANGE_W'(cash_reg);
                    end
                    ok = 1'b1;
                end
            end
            REQ_CASH:
            begin
                if (phase_reg == PH_WELCOME && amt != '0)
                begin
                    phase_next = PH_SELECT;
                    card_next  = 1'b0;
                    cash_next  = amt;
                    ok         = 1'b1;
                end
            end
            REQ_REGULAR, REQ_SUPER:
            begin
                if (phase_reg == PH_SELECT)
                begin
                    price_next = (req_type == REQ_REGULAR) ? reg_latch_reg : sup_latch_reg;
                    phase_next = PH_SELECTED;
                    ok         = 1'b1;
                end
            end
            REQ_STARTPUMP:
            begin
                if (phase_reg == PH_SELECTED)
                begin
                    phase_next = PH_PUMP;
                    gal_next   = '0;
                    total_next = '0;
                    ok         = 1'b1;
                end
            end
            REQ_GALLON:
            begin
                if (phase_reg == PH_PUMP)
                begin
                    if (gallon_fits)
                    begin
                        // count saturates: a gallon at the max is refused
                        if (gal_reg != GAL_MAX)
                        begin
                            gal_next   = gal_reg + 1'b1;
                            total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                            ok         = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_RECEIPT;
                        change     = change_due;
                        exhausted  = 1'b1;
                        ok         = 1'b1;
                    end
                end
            end
            REQ_STOP:
            begin
                if (phase_reg == PH_PUMP)
                begin
                    phase_next = PH_RECEIPT;
                    change     = change_due;
                    ok         = 1'b1;
                end
            end
            REQ_NORECEIPT, REQ_RECEIPT:
            begin
                if (phase_reg == PH_RECEIPT)
                begin
                    phase_next = PH_IDLE;
                    ok         = 1'b1;
                end
            end
            REQ_OFF:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_OFF;
                    ok         = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Result reflects the state after the event
    always_comb
    begin
        result.accepted        = ok;
        result.phase           = phase_next;
        result.gallons_pumped  = gal_next;
        result.total_charge    = total_next;
        result.change_returned = change;
        result.funds_exhausted = exhausted;
    end

    // State commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_UNACT;
            card_reg      <= 1'b0;
            price_reg     <= '0;
            gal_reg       <= '0;
            total_reg     <= '0;
            cash_reg      <= '0;
            reg_latch_reg <= '0;
            sup_latch_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            card_reg      <= card_next;
            price_reg     <= price_next;
            gal_reg       <= gal_next;
            total_reg     <= total_next;
            cash_reg      <= cash_next;
            reg_latch_reg <= reg_latch_next;
            sup_latch_reg <= sup_latch_next;
        end
    end

endmodule

FILE: rtl/fuel_dispenser_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser controller
// Event-driven dispenser sale controller with stream in/out channels.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis channel, one event per beat. Each event gives
//   exactly one result beat on m_axis: accept flag, phase, gallon count,
//   charge, change handed back and the out-of-funds flag.
//   Prices are written on the cfg port (index 0 regular, 1 super) while no
//   event is in flight; they are latched by the activate event.
// Timing:
//   An event is registered at the input, evaluated by the event core from
//   the input register and its result registered at the output. The input
//   register and the output register form a two-stage pipeline, so one
//   event per cycle is sustained while m_axis_tready stays high.
// Stall:
//   While m_axis_tready is low the output register holds its beat; the
//   input register fills and s_axis_tready drops until the result drains.
// Reset:
//   rst_n clears both pipeline stages, the prices and the sale state; the
//   controller starts unactivated.
// ----------------------------------------------------------------------------
module fuel_dispenser_controller_top #(
    parameter int MONEY_BITS = fdc_pkg::MONEY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // event input: [3:0] req_type, [19:4] cash_amount, rest zero
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fdc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // result output: [0] accepted, [4:1] phase, [20:5] gallons_pumped,
    // [52:21] total_charge, [68:53] change_returned, [69] funds_exhausted
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fdc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import fdc_pkg::*;

    logic [MONEY_BITS-1:0] regular_price;
    logic [MONEY_BITS-1:0] super_price;

    logic              in_vld_reg;
    logic [REQ_W-1:0]  in_req_reg;
    logic [CASH_W-1:0] in_cash_reg;
    logic              out_vld_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance;
    logic              fire;

    // Price registers
    fdc_cfg_regs #(
        .MONEY_BITS (MONEY_BITS)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .regular_price (regular_price),
        .super_price   (super_price)
    );

    // Pipeline flow control
    assign advance       = !out_vld_reg || m_axis_tready;
    assign fire          = in_vld_reg && advance;
    assign s_axis_tready = !in_vld_reg || advance;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg  <= s_axis_tdata[REQ_W-1:0];
            in_cash_reg <= s_axis_tdata[REQ_W +: CASH_W];
        end
    end

    // Event core
    fdc_core #(
        .MONEY_BITS (MONEY_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .req_type      (in_req_reg),
        .cash_amount   (in_cash_reg),
        .regular_price (regular_price),
        .super_price   (super_price),
        .result        (result)
    );

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_reg};

endmodule

FILE: rtl/fdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module fdc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fdc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import fdc_pkg::*;

    result_t res;

    assign res = m_axis_tdata[OUT_BITS-1:0];

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Out-of-funds stop is an accepted move to receipt choice
    a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.funds_exhausted |-> res.accepted && res.phase == PH_RECEIPT)
        else $error("funds exhausted without accepted stop");

    // Change is only handed back by an accepted event
    a_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.change_returned != '0 |-> res.accepted)
        else $error("change returned by refused event");

    // Before activation no sale has run
    a_unact_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.phase == PH_UNACT |->
            res.gallons_pumped == '0 && res.total_charge == '0)
        else $error("sale counters nonzero before activation");

endmodule

bind fuel_dispenser_controller_top fdc_checker u_fdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel dispenser controller testbench
// Streams sale events into the controller and checks every result beat
// against a cycle-free sale predictor kept in this file. The run covers
// activation with missing prices, a directed set of card and cash sales,
// random sales mixed with stray events, a card sale at the highest latched
// price after the price registers were rewritten, and finally the off state.
// ----------------------------------------------------------------------------
module tb_top;
    import fdc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_EVENTS = 340;
    localparam int GAL_RUN       = 20;
    localparam int IDLE_PCT      = 29;
    localparam logic [REQ_W-1:0]   REQ_UNUSED = 4'd15;
    localparam logic [PRICE_W-1:0] PRICE_MAX  = '1;
    localparam logic [CASH_W-1:0]  CASH_MAX   = '1;

    // One sale event, packed as it travels in tdata (code in the low bits)
    typedef struct packed {
        logic [CASH_W-1:0] cash;
        logic [REQ_W-1:0]  code;
    } sale_evt_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_REG_REGULAR;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // Event and result stores
    sale_evt_t pending_evts[$];
    result_t   expected_results[$];
    sale_evt_t evt_on_bus;

    int queued_cnt     = 0;
    int evts_accepted  = 0;
    int results_seen   = 0;
    int mismatch_cnt   = 0;
    int cycle_cnt      = 0;
    int exhaust_cnt    = 0;
    int refused_cnt    = 0;

    // Sale predictor state
    logic [PRICE_W-1:0] price_regular   = '0;
    logic [PRICE_W-1:0] price_super     = '0;
    logic [PRICE_W-1:0] latched_regular = '0;
    logic [PRICE_W-1:0] latched_super   = '0;
    phase_t             dsp_phase       = PH_UNACT;
    logic               dsp_card        = 1'b0;
    logic [PRICE_W-1:0] dsp_price       = '0;
    logic [GAL_W-1:0]   dsp_gal         = '0;
    logic [TOTAL_W-1:0] dsp_total       = '0;
    logic [CASH_W-1:0]  dsp_cash        = '0;

    fuel_dispenser_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Cash handed back when a cash sale ends
    function automatic logic [CHANGE_W-1:0] cash_back();
        logic [TOTAL_W-1:0] diff;
        diff = '0;
        if (!dsp_card && dsp_total < TOTAL_W'(dsp_cash))
            diff = TOTAL_W'(dsp_cash) - dsp_total;
        return diff[CHANGE_W-1:0];
    endfunction

    // Applies one event to the sale state, returns the result it gives
    function automatic result_t dispense_step(input sale_evt_t e);
        result_t            r;
        logic [TOTAL_W:0]   next_total;
        logic               ok;
        logic [CHANGE_W-1:0] change;
        logic               exhausted;
        ok         = 1'b0;
        change     = '0;
        exhausted  = 1'b0;
        next_total = {1'b0, dsp_total} + (TOTAL_W + 1)'(dsp_price);
        case (e.code)
            REQ_ACTIVATE:
            begin
                if (dsp_phase == PH_UNACT && price_regular != 0 && price_super != 0)
                begin
                    latched_regular = price_regular;
                    latched_super   = price_super;
                    dsp_phase       = PH_IDLE;
                    ok              = 1'b1;
                end
            end
            REQ_START:
            begin
                if (dsp_phase == PH_IDLE)
                begin
                    dsp_phase = PH_WELCOME;
                    ok        = 1'b1;
                end
            end
            REQ_CREDIT:
            begin
                if (dsp_phase == PH_WELCOME)
                begin
                    dsp_phase = PH_CHECK;
                    ok        = 1'b1;
                end
            end
            REQ_REJECT:
            begin
                if (dsp_phase == PH_CHECK)
                begin
                    dsp_phase = PH_IDLE;
                    ok        = 1'b1;
                end
            end
            REQ_APPROVED:
            begin
                if (dsp_phase == PH_CHECK)
                begin
                    dsp_phase = PH_SELECT;
                    dsp_card  = 1'b1;
                    ok        = 1'b1;
                end
            end
            REQ_CANCEL:
            begin
                if (dsp_phase == PH_SELECT)
                begin
                    dsp_phase = PH_IDLE;
                    if (!dsp_card)
                        change = dsp_cash;
                    ok = 1'b1;
                end
            end
            REQ_CASH:
            begin
                if (dsp_phase == PH_WELCOME && e.cash != 0)
                begin
                    dsp_phase = PH_SELECT;
                    dsp_card  = 1'b0;
                    dsp_cash  = e.cash;
                    ok        = 1'b1;
                end
            end
            REQ_REGULAR, REQ_SUPER:
            begin
                if (dsp_phase == PH_SELECT)
                begin
                    dsp_price = (e.code == REQ_REGULAR) ? latched_regular : latched_super;
                    dsp_phase = PH_SELECTED;
                    ok        = 1'b1;
                end
            end
            REQ_STARTPUMP:
            begin
                if (dsp_phase == PH_SELECTED)
                begin
                    dsp_phase = PH_PUMP;
                    dsp_gal   = '0;
                    dsp_total = '0;
                    ok        = 1'b1;
                end
            end
            REQ_GALLON:
            begin
                if (dsp_phase == PH_PUMP)
                begin
                    if (dsp_card || next_total <= (TOTAL_W + 1)'(dsp_cash))
                    begin
                        // count saturates: a gallon past the maximum is refused
                        if (dsp_gal != GAL_MAX)
                        begin
                            dsp_gal   = dsp_gal + 1'b1;
                            dsp_total = next_total[TOTAL_W] ? TOTAL_MAX
                                                            : next_total[TOTAL_W-1:0];
                            ok        = 1'b1;
                        end
                    end
                    else
                    begin
                        // not enough cash for the next gallon
                        dsp_phase = PH_RECEIPT;
                        change    = cash_back();
                        exhausted = 1'b1;
                        ok        = 1'b1;
                    end
                end
            end
            REQ_STOP:
            begin
                if (dsp_phase == PH_PUMP)
                begin
                    dsp_phase = PH_RECEIPT;
                    change    = cash_back();
                    ok        = 1'b1;
                end
            end
            REQ_NORECEIPT, REQ_RECEIPT:
            begin
                if (dsp_phase == PH_RECEIPT)
                begin
                    dsp_phase = PH_IDLE;
                    ok        = 1'b1;
                end
            end
            REQ_OFF:
            begin
                if (dsp_phase == PH_IDLE)
                begin
                    dsp_phase = PH_OFF;
                    ok        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.accepted        = ok;
        r.phase           = dsp_phase;
        r.gallons_pumped  = dsp_gal;
        r.total_charge    = dsp_total;
        r.change_returned = change;
        r.funds_exhausted = exhausted;
        return r;
    endfunction

    // Random back-pressure, with a quiet window every 4096 beats
    function automatic bit hold_back(input int beats);
        int k;
        k = beats % 4096;
        if (k >= 200 && k < 330)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic void note_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("MISMATCH result %0d %s: expected %0h, got %0h",
                     results_seen, what, want, got);
    endfunction

    // Compares one result beat with the oldest expectation
    function automatic void check_result(input result_t got);
        result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            note_mismatch("unexpected beat", 0, 1);
            return;
        end
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted)
            note_mismatch("accepted", want.accepted, got.accepted);
        if (got.phase !== want.phase)
            note_mismatch("phase", want.phase, got.phase);
        if (got.gallons_pumped !== want.gallons_pumped)
            note_mismatch("gallons_pumped", want.gallons_pumped, got.gallons_pumped);
        if (got.total_charge !== want.total_charge)
            note_mismatch("total_charge", want.total_charge, got.total_charge);
        if (got.change_returned !== want.change_returned)
            note_mismatch("change_returned", want.change_returned, got.change_returned);
        if (got.funds_exhausted !== want.funds_exhausted)
            note_mismatch("funds_exhausted", want.funds_exhausted, got.funds_exhausted);
    endfunction

    // Event driver: predicts on each accepted beat, then loads the next event
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(dispense_step(evt_on_bus));
                if (!expected_results[$].accepted)
                    refused_cnt++;
                if (expected_results[$].funds_exhausted)
                    exhaust_cnt++;
                evts_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_evts.size() != 0 && !hold_back(evts_accepted))
                begin
                    evt_on_bus = pending_evts.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, evt_on_bus};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(result_t'(m_axis_tdata[OUT_BITS-1:0]));
            m_axis_tready <= !hold_back(results_seen);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_cnt, expected_results.size());
            $display("** fuel_dispenser_controller_top: FAILED **");
            $finish;
        end
    end

    function automatic logic [CASH_W-1:0] rnd_cash();
        return CASH_W'($urandom_range(0, 65535));
    endfunction

    function automatic void queue_evt(input logic [REQ_W-1:0] code,
                                      input logic [CASH_W-1:0] cash);
        sale_evt_t e;
        e.code = code;
        e.cash = cash;
        pending_evts.push_back(e);
        queued_cnt++;
    endfunction

    // One well-formed sale with random payment, grade and length
    function automatic void queue_sale();
        int                n_gal;
        logic [CASH_W-1:0] amt;
        queue_evt(REQ_START, rnd_cash());
        if ($urandom_range(0, 1))
        begin
            queue_evt(REQ_CREDIT, rnd_cash());
            if ($urandom_range(0, 4) == 0)
            begin
                queue_evt(REQ_REJECT, rnd_cash());
                return;
            end
            queue_evt(REQ_APPROVED, rnd_cash());
        end
        else
        begin
            // mostly small amounts so the cash limit is hit often
            amt = ($urandom_range(0, 3) == 0) ? rnd_cash()
                                              : CASH_W'($urandom_range(1, 15));
            queue_evt(REQ_CASH, amt);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            queue_evt(REQ_CANCEL, rnd_cash());
            return;
        end
        queue_evt(($urandom_range(0, 3) == 0) ? REQ_SUPER : REQ_REGULAR, rnd_cash());
        queue_evt(REQ_STARTPUMP, rnd_cash());
        n_gal = $urandom_range(0, 12);
        repeat (n_gal) queue_evt(REQ_GALLON, rnd_cash());
        if ($urandom_range(0, 1))
            queue_evt(REQ_STOP, rnd_cash());
        queue_evt($urandom_range(0, 1) ? REQ_RECEIPT : REQ_NORECEIPT, rnd_cash());
    endfunction

    // Stray events of any code except off
    function automatic void queue_noise();
        int               n;
        logic [REQ_W-1:0] c;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            c = REQ_W'($urandom_range(0, 15));
            if (c == REQ_OFF)
                c = REQ_UNUSED;
            queue_evt(c, rnd_cash());
        end
    endfunction

    // Walks the predicted phase back to idle
    function automatic void queue_back_to_idle();
        case (dsp_phase)
            PH_WELCOME:
            begin
                queue_evt(REQ_CREDIT, '0);
                queue_evt(REQ_REJECT, '0);
            end
            PH_CHECK:    queue_evt(REQ_REJECT, '0);
            PH_SELECT:   queue_evt(REQ_CANCEL, '0);
            PH_SELECTED:
            begin
                queue_evt(REQ_STARTPUMP, '0);
                queue_evt(REQ_STOP, '0);
                queue_evt(REQ_NORECEIPT, '0);
            end
            PH_PUMP:
            begin
                queue_evt(REQ_STOP, '0);
                queue_evt(REQ_NORECEIPT, '0);
            end
            PH_RECEIPT:  queue_evt(REQ_NORECEIPT, '0);
            default:
            begin
            end
        endcase
    endfunction

    task automatic write_price(input cfg_idx_t idx, input logic [PRICE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REG_REGULAR)
            price_regular = val;
        else
            price_super = val;
        @(negedge clk);
    endtask

    // Waits until every queued event has been sent and answered
    task automatic drain();
        @(negedge clk);
        while (pending_evts.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int mark;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing works before activation; activation needs both prices
        queue_evt(REQ_START, CASH_MAX);
        queue_evt(REQ_ACTIVATE, '0);
        drain();
        write_price(CFG_REG_REGULAR, PRICE_MAX);
        queue_evt(REQ_ACTIVATE, '0);
        drain();

        // lowest and highest prices get latched
        write_price(CFG_REG_REGULAR, 16'd1);
        write_price(CFG_REG_SUPER, PRICE_MAX);
        queue_evt(REQ_ACTIVATE, '0);
        queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_UNUSED, CASH_MAX);
        // card rejected, then card approved and cancelled
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CREDIT, '0);
        queue_evt(REQ_REJECT, '0);
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CREDIT, '0);
        queue_evt(REQ_APPROVED, '0);
        queue_evt(REQ_CANCEL, '0);
        // zero cash refused, full cash cancelled with all of it back
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CASH, '0);
        queue_evt(REQ_CASH, CASH_MAX);
        queue_evt(REQ_CANCEL, '0);
        // cash covers exactly one super gallon, the next runs out
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CASH, CASH_MAX);
        queue_evt(REQ_SUPER, '0);
        queue_evt(REQ_STARTPUMP, '0);
        queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_NORECEIPT, '0);
        // cash sale stopped early, change back
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CASH, 16'd5);
        queue_evt(REQ_REGULAR, '0);
        queue_evt(REQ_STARTPUMP, '0);
        queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_STOP, '0);
        queue_evt(REQ_RECEIPT, '0);
        drain();

        // price writes after activation must not matter
        write_price(CFG_REG_REGULAR, '0);
        write_price(CFG_REG_SUPER, '0);
        mark = queued_cnt;
        while (queued_cnt - mark < RANDOM_EVENTS)
        begin
            if ($urandom_range(0, 5) == 0)
                queue_noise();
            queue_sale();
        end
        drain();

        // card sale at the highest latched price after new price writes
        write_price(CFG_REG_REGULAR, PRICE_MAX);
        write_price(CFG_REG_SUPER, 16'h1234);
        queue_back_to_idle();
        queue_evt(REQ_START, '0);
        queue_evt(REQ_CREDIT, '0);
        queue_evt(REQ_APPROVED, '0);
        queue_evt(REQ_SUPER, '0);
        queue_evt(REQ_STARTPUMP, '0);
        repeat (GAL_RUN) queue_evt(REQ_GALLON, '0);
        queue_evt(REQ_STOP, '0);
        queue_evt(REQ_NORECEIPT, '0);
        drain();

        // switch off; everything afterwards is refused
        queue_back_to_idle();
        queue_evt(REQ_OFF, '0);
        queue_evt(REQ_START, '0);
        queue_evt(REQ_ACTIVATE, '0);
        queue_evt(REQ_OFF, '0);
        drain();

        // pipeline is two deep; give stray beats time to show up
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results missing", expected_results.size(), 0);

        $display("%0d events sent, %0d results checked, %0d refused, %0d out of cash",
                 evts_accepted, results_seen, refused_cnt, exhaust_cnt);
        $display("%0d mismatches in %0d cycles", mismatch_cnt, cycle_cnt);
        if (mismatch_cnt == 0)
            $display("** fuel_dispenser_controller_top: PASSED **");
        else
            $display("** fuel_dispenser_controller_top: FAILED **");
        $finish;
    end

endmodule
